// ===== hw/rtl/hrlp_pkg.sv =====
`timescale 1ns / 1ps

package hrlp_pkg;

    typedef logic [7:0] char_t;

    localparam int MAX_REQUEST_BYTES_DEF = 4096;
    localparam int FIELD_W = 13;
    localparam int NUM_VERBS = 8;

    // Parser phases.
    localparam logic [2:0] PH_METHOD    = 3'd0;
    localparam logic [2:0] PH_URI_FIRST = 3'd1;
    localparam logic [2:0] PH_URI       = 3'd2;
    localparam logic [2:0] PH_VER_FIRST = 3'd3;
    localparam logic [2:0] PH_VER       = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD     = 2'd1;
    localparam logic [1:0] ST_VERSION = 2'd2;

    localparam char_t CH_NUL   = 8'h00;
    localparam char_t CH_LF    = 8'h0A;
    localparam char_t CH_CR    = 8'h0D;
    localparam char_t CH_SPACE = 8'h20;
    localparam char_t CH_QUERY = 8'h3F;
    localparam char_t CH_UPPER_A = 8'h41;
    localparam char_t CH_UPPER_Z = 8'h5A;
    localparam char_t CASE_OFFSET = 8'd32;

    localparam logic [3:0] VER_LEN = 4'd8;
    localparam logic [3:0] VER_SATURATE = 4'd9;
    localparam logic [2:0] METHOD_IDX_MAX = 3'd7;

    // Lower-case method spellings, get through head.
    localparam char_t VERB_TEXT [0:NUM_VERBS-1][0:7] = '{
        '{"g", "e", "t", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"p", "o", "s", "t", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"p", "u", "t", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"d", "e", "l", "e", "t", "e", CH_NUL, CH_NUL},
        '{"c", "o", "n", "n", "e", "c", "t", CH_NUL},
        '{"o", "p", "t", "i", "o", "n", "s", CH_NUL},
        '{"t", "r", "a", "c", "e", CH_NUL, CH_NUL, CH_NUL},
        '{"h", "e", "a", "d", CH_NUL, CH_NUL, CH_NUL, CH_NUL}
    };

    localparam logic [2:0] VERB_LEN [0:NUM_VERBS-1] = '{
        3'd3, 3'd4, 3'd3, 3'd6, 3'd7, 3'd7, 3'd5, 3'd4
    };

    localparam char_t PROTO_TEXT [0:7] = '{"h", "t", "t", "p", "/", "1", ".", "1"};

    typedef struct packed {
        logic [1:0]         status;
        logic [2:0]         method_code;
        logic [FIELD_W-1:0] path_length;
        logic               has_query;
        logic [FIELD_W-1:0] query_length;
        logic [FIELD_W-1:0] header_offset;
    } hrlp_result_t;

    function automatic char_t fold_case(input char_t c);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/hrlp_match.sv =====
`timescale 1ns / 1ps

module hrlp_match
    import hrlp_pkg::*;
(
    input  char_t      lc_byte,
    input  logic [7:0] cand,
    input  logic [2:0] method_idx,
    input  logic [3:0] ver_idx,
    output logic [7:0] cand_next,
    output logic [2:0] verb_code,
    output logic       verb_ok,
    output logic       ver_char_ok
);

    always_comb
    begin
        for (int k = 0; k < NUM_VERBS; k++)
        begin
            cand_next[k] = cand[k] && (method_idx < VERB_LEN[k])
                && (VERB_TEXT[k][method_idx] == lc_byte);
        end
    end

    // The lowest candidate whose full spelling has been consumed wins.
    always_comb
    begin
        verb_code = 3'd0;
        verb_ok   = 1'b0;
        for (int k = NUM_VERBS - 1; k >= 0; k--)
        begin
            if (cand[k] && VERB_LEN[k] == method_idx)
            begin
                verb_code = 3'(k);
                verb_ok   = 1'b1;
            end
        end
    end

    assign ver_char_ok = (ver_idx < VER_LEN) && (PROTO_TEXT[ver_idx[2:0]] == lc_byte);

endmodule

// ===== hw/rtl/hrlp_core.sv =====
`timescale 1ns / 1ps

module hrlp_core
    import hrlp_pkg::*;
#(
    parameter int MAX_REQUEST_BYTES = MAX_REQUEST_BYTES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         go,
    input  char_t        data_byte,
    input  logic         last_byte,
    output logic         res_valid,
    output hrlp_result_t res
);

    localparam int POS_W = $clog2(MAX_REQUEST_BYTES + 1);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_REQUEST_BYTES);

    logic [2:0]       phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       cand_reg, cand_next;
    logic [2:0]       midx_reg, midx_next;
    logic             vmatch_reg, vmatch_next;
    logic [3:0]       vidx_reg, vidx_next;
    logic [POS_W-1:0] uri_reg, uri_next;
    logic [POS_W-1:0] qstart_reg, qstart_next;
    logic             qseen_reg, qseen_next;
    logic             cr_reg, cr_next;
    logic             sent_reg, sent_next;

    char_t            lc_byte;
    logic [7:0]       match_cand;
    logic [2:0]       verb_code;
    logic             verb_ok;
    logic             ver_char_ok;
    logic [POS_W-1:0] pos_inc;
    logic             is_space;
    logic             bad_emit;
    logic             line_emit;
    logic             take_uri;
    logic [POS_W-1:0] plen;
    logic [POS_W-1:0] qlen;
    logic [POS_W+FIELD_W-1:0] plen_wide;
    logic [POS_W+FIELD_W-1:0] qlen_wide;
    logic [POS_W+FIELD_W-1:0] pos_wide;

    assign lc_byte  = fold_case(data_byte);
    assign pos_inc  = pos_reg + 1'b1;
    assign is_space = (data_byte == CH_SPACE);

    hrlp_match u_match (
        .lc_byte     (lc_byte),
        .cand        (cand_reg),
        .method_idx  (midx_reg),
        .ver_idx     (vidx_reg),
        .cand_next   (match_cand),
        .verb_code   (verb_code),
        .verb_ok     (verb_ok),
        .ver_char_ok (ver_char_ok)
    );

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        cand_next   = cand_reg;
        midx_next   = midx_reg;
        vmatch_next = vmatch_reg;
        vidx_next   = vidx_reg;
        uri_next    = uri_reg;
        qstart_next = qstart_reg;
        qseen_next  = qseen_reg;
        cr_next     = cr_reg;
        sent_next   = sent_reg;
        bad_emit    = 1'b0;
        line_emit   = 1'b0;
        take_uri    = 1'b0;

        if (go)
        begin
            if (!sent_reg)
            begin
                if (data_byte == CH_NUL)
                begin
                    bad_emit = 1'b1;
                end
                else
                begin
                    pos_next = pos_inc;
                    case (phase_reg)
                        PH_METHOD:
                        begin
                            if (is_space)
                            begin
                                phase_next = PH_URI_FIRST;
                            end
                            else
                            begin
                                cand_next = match_cand;
                                if (midx_reg != METHOD_IDX_MAX)
                                begin
                                    midx_next = midx_reg + 1'b1;
                                end
                            end
                        end
                        PH_URI_FIRST:
                        begin
                            if (is_space || !verb_ok)
                            begin
                                bad_emit = 1'b1;
                            end
                            else
                            begin
                                take_uri   = 1'b1;
                                phase_next = PH_URI;
                            end
                        end
                        PH_URI:
                        begin
                            if (is_space)
                            begin
                                phase_next = PH_VER_FIRST;
                            end
                            else
                            begin
                                take_uri = 1'b1;
                            end
                        end
                        default:
                        begin
                            // Version field; its first byte may not be a space.
                            if (phase_reg == PH_VER_FIRST && is_space)
                            begin
                                bad_emit = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_VER;
                                if (cr_reg)
                                begin
                                    if (data_byte == CH_LF)
                                    begin
                                        line_emit = 1'b1;
                                    end
                                    else
                                    begin
                                        bad_emit = 1'b1;
                                    end
                                end
                                else if (data_byte == CH_CR)
                                begin
                                    cr_next = 1'b1;
                                end
                                else if (data_byte == CH_LF)
                                begin
                                    line_emit = 1'b1;
                                end
                                else
                                begin
                                    if (!ver_char_ok)
                                    begin
                                        vmatch_next = 1'b0;
                                    end
                                    if (vidx_reg < VER_SATURATE)
                                    begin
                                        vidx_next = vidx_reg + 1'b1;
                                    end
                                end
                            end
                        end
                    endcase
                    if (!bad_emit && !line_emit && pos_inc >= MAX_POS)
                    begin
                        bad_emit = 1'b1;
                    end
                end
            end

            if (take_uri)
            begin
                if (data_byte == CH_QUERY && !qseen_reg)
                begin
                    qseen_next  = 1'b1;
                    qstart_next = uri_reg;
                end
                uri_next = uri_reg + 1'b1;
            end

            // A request cut short by its final byte is malformed.
            if (!sent_reg && last_byte && !bad_emit && !line_emit)
            begin
                bad_emit = 1'b1;
            end
            if (bad_emit || line_emit)
            begin
                sent_next = 1'b1;
            end

            if (last_byte)
            begin
                phase_next  = PH_METHOD;
                pos_next    = '0;
                cand_next   = '1;
                midx_next   = '0;
                vmatch_next = 1'b1;
                vidx_next   = '0;
                uri_next    = '0;
                qstart_next = '0;
                qseen_next  = 1'b0;
                cr_next     = 1'b0;
                sent_next   = 1'b0;
            end
        end
    end

    assign plen = qseen_reg ? qstart_reg : uri_reg;
    assign qlen = qseen_reg ? (uri_reg - qstart_reg - 1'b1) : '0;
    assign plen_wide = {{FIELD_W{1'b0}}, plen};
    assign qlen_wide = {{FIELD_W{1'b0}}, qlen};
    assign pos_wide  = {{FIELD_W{1'b0}}, pos_inc};

    assign res_valid = bad_emit || line_emit;

    always_comb
    begin
        res = '0;
        if (bad_emit)
        begin
            res.status = ST_BAD;
        end
        else
        begin
            res.status = (vmatch_reg && vidx_reg == VER_LEN) ? ST_OK : ST_VERSION;
            res.method_code   = verb_code;
            res.path_length   = plen_wide[FIELD_W-1:0];
            res.has_query     = qseen_reg;
            res.query_length  = qlen_wide[FIELD_W-1:0];
            res.header_offset = pos_wide[FIELD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_METHOD;
            pos_reg    <= '0;
            cand_reg   <= '1;
            midx_reg   <= '0;
            vmatch_reg <= 1'b1;
            vidx_reg   <= '0;
            uri_reg    <= '0;
            qstart_reg <= '0;
            qseen_reg  <= 1'b0;
            cr_reg     <= 1'b0;
            sent_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            cand_reg   <= cand_next;
            midx_reg   <= midx_next;
            vmatch_reg <= vmatch_next;
            vidx_reg   <= vidx_next;
            uri_reg    <= uri_next;
            qstart_reg <= qstart_next;
            qseen_reg  <= qseen_next;
            cr_reg     <= cr_next;
            sent_reg   <= sent_next;
        end
    end

`ifndef SYNTH
    a_rearm_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        go && last_byte |=> phase_reg == PH_METHOD && !sent_reg && pos_reg == '0)
        else $error("parser not rearmed after final byte");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        sent_reg |-> !res_valid)
        else $error("second result for one request");

    a_result_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> go)
        else $error("result without a byte");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !sent_reg |-> pos_reg < MAX_POS)
        else $error("byte position past limit while parsing");
`endif

endmodule

// ===== hw/rtl/hrlp_obuf.sv =====
`timescale 1ns / 1ps

module hrlp_obuf
    import hrlp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  hrlp_result_t push_data,
    output logic         room,
    output logic         out_valid,
    input  logic         out_stall,
    output hrlp_result_t out_data
);

    logic [1:0]   count_reg, count_next;
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    hrlp_result_t mem_reg [2];
    logic         pop;

    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;
    assign room      = (count_reg != 2'd2);

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/http_request_line_parser.sv =====
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// input    in_valid, in_stall   data_byte[7:0], last_byte
// output   out_valid, out_stall status[1:0], method_code[2:0], path_length[12:0],
//                               has_query, query_length[12:0], header_offset[12:0]
//
// One byte is taken per cycle unless the input stalls; each byte is held in the input
// register, and its result, if any, is written to a two-entry output queue.
// Rate is set by the combinational parse step against the parser state registers.
// Reset clears the parser to the method phase and empties both stages.
// The input stalls only while a byte is held and the output queue is full.

module http_request_line_parser
    import hrlp_pkg::*;
#(
    parameter int MAX_REQUEST_BYTES = MAX_REQUEST_BYTES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [1:0]   status,
    output logic [2:0]   method_code,
    output logic [FIELD_W-1:0] path_length,
    output logic         has_query,
    output logic [FIELD_W-1:0] query_length,
    output logic [FIELD_W-1:0] header_offset
);

    logic         held_reg;
    char_t        byte_reg;
    logic         last_reg;
    logic         room;
    logic         go;
    logic         accept;
    logic         res_valid;
    hrlp_result_t res;
    hrlp_result_t out_data;

    assign go       = held_reg && room;
    assign in_stall = held_reg && !room;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else if (accept)
        begin
            held_reg <= 1'b1;
        end
        else if (go)
        begin
            held_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    hrlp_core #(
        .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .data_byte (byte_reg),
        .last_byte (last_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    hrlp_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign status        = out_data.status;
    assign method_code   = out_data.method_code;
    assign path_length   = out_data.path_length;
    assign has_query     = out_data.has_query;
    assign query_length  = out_data.query_length;
    assign header_offset = out_data.header_offset;

endmodule

// ===== test/tb_http_request_line_parser.sv =====
`timescale 1ns / 1ps

module tb_http_request_line_parser
    import hrlp_pkg::*;
();

    class line_result_checker;
        hrlp_result_t pending_results[$];
        int errors;
        string verbs[8];
        string proto;

        // Shadow of the parser state.
        logic [2:0] phase;
        int unsigned position;
        logic [7:0] candidates;
        int unsigned method_index;
        bit version_ok;
        int unsigned version_index;
        int unsigned uri_count;
        int unsigned query_start;
        bit query_seen;
        bit cr_seen;
        bit done;

        function new();
            verbs = '{"get", "post", "put", "delete", "connect", "options", "trace", "head"};
            proto = "http/1.1";
            errors = 0;
            rearm();
        endfunction

        function void rearm();
            phase = PH_METHOD;
            position = 0;
            candidates = 8'hFF;
            method_index = 0;
            version_ok = 1'b1;
            version_index = 0;
            uri_count = 0;
            query_start = 0;
            query_seen = 1'b0;
            cr_seen = 1'b0;
            done = 1'b0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Index of the method that survived matching, 8 when there is none.
        function int matched_verb();
            for (int k = 0; k < 8; k++)
            begin
                if (candidates[k] && verbs[k].len() == method_index)
                    return k;
            end
            return 8;
        endfunction

        function void emit_bad(output hrlp_result_t r);
            r = '0;
            r.status = ST_BAD;
            done = 1'b1;
        endfunction

        function void emit_line(output hrlp_result_t r);
            int unsigned plen;
            int unsigned qlen;
            plen = query_seen ? query_start : uri_count;
            qlen = query_seen ? uri_count - query_start - 1 : 0;
            r.status = (version_ok && version_index == 8) ? ST_OK : ST_VERSION;
            r.method_code = 3'(matched_verb());
            r.path_length = FIELD_W'(plen);
            r.has_query = query_seen;
            r.query_length = FIELD_W'(qlen);
            r.header_offset = FIELD_W'(position);
            done = 1'b1;
        endfunction

        function void take_uri(input logic [7:0] c);
            if (c == CH_QUERY && !query_seen)
            begin
                query_seen = 1'b1;
                query_start = uri_count;
            end
            uri_count++;
        endfunction

        function bit parse_request_byte(input logic [7:0] c, output hrlp_result_t r);
            logic [7:0] lc;
            r = '0;
            lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
            if (phase == PH_METHOD)
            begin
                if (c == CH_SPACE)
                    phase = PH_URI_FIRST;
                else
                begin
                    for (int k = 0; k < 8; k++)
                    begin
                        if (!(method_index < verbs[k].len() && verbs[k][method_index] == lc))
                            candidates[k] = 1'b0;
                    end
                    if (method_index < 7)
                        method_index++;
                end
                return 1'b0;
            end
            if (phase == PH_URI_FIRST)
            begin
                if (c == CH_SPACE || matched_verb() == 8)
                begin
                    emit_bad(r);
                    return 1'b1;
                end
                take_uri(c);
                phase = PH_URI;
                return 1'b0;
            end
            if (phase == PH_URI)
            begin
                if (c == CH_SPACE)
                    phase = PH_VER_FIRST;
                else
                    take_uri(c);
                return 1'b0;
            end
            if (phase == PH_VER_FIRST)
            begin
                if (c == CH_SPACE)
                begin
                    emit_bad(r);
                    return 1'b1;
                end
                phase = PH_VER;
            end
            // A CR must be followed directly by LF.
            if (cr_seen)
            begin
                if (c == CH_LF)
                    emit_line(r);
                else
                    emit_bad(r);
                return 1'b1;
            end
            if (c == CH_CR)
            begin
                cr_seen = 1'b1;
                return 1'b0;
            end
            if (c == CH_LF)
            begin
                emit_line(r);
                return 1'b1;
            end
            if (!(version_index < 8 && proto[version_index] == lc))
                version_ok = 1'b0;
            if (version_index < 9)
                version_index++;
            return 1'b0;
        endfunction

        // Each accepted request byte is folded into the shadow state; any result is queued.
        function void note_request_byte(input logic [7:0] c, input bit fin);
            hrlp_result_t r;
            bit got;
            got = 1'b0;
            r = '0;
            if (!done)
            begin
                if (c == CH_NUL)
                begin
                    emit_bad(r);
                    got = 1'b1;
                end
                else
                begin
                    position++;
                    got = parse_request_byte(c, r);
                    if (!got && position >= MAX_REQUEST_BYTES_DEF)
                    begin
                        emit_bad(r);
                        got = 1'b1;
                    end
                end
            end
            if (!done && fin)
            begin
                emit_bad(r);
                got = 1'b1;
            end
            if (fin)
                rearm();
            if (got)
                pending_results.push_back(r);
        endfunction

        function void compare_field(input string name, input int unsigned want,
                                    input int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(input hrlp_result_t actual);
            hrlp_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result with no request pending: status %0d", actual.status);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", want.status, actual.status);
            compare_field("method_code", want.method_code, actual.method_code);
            compare_field("path_length", want.path_length, actual.path_length);
            compare_field("has_query", want.has_query, actual.has_query);
            compare_field("query_length", want.query_length, actual.query_length);
            compare_field("header_offset", want.header_offset, actual.header_offset);
        endfunction
    endclass

    localparam int BYTE_TARGET = 850;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES = 80;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [7:0] data_byte = 8'h00;
    logic last_byte = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] status;
    logic [2:0] method_code;
    logic [FIELD_W-1:0] path_length;
    logic has_query;
    logic [FIELD_W-1:0] query_length;
    logic [FIELD_W-1:0] header_offset;

    int idle_pct = 16;
    int stall_pct = 16;
    int hold_trigger = 0;
    int cycle_count = 0;

    line_result_checker line_check;

    http_request_line_parser dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .last_byte(last_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .method_code(method_code),
        .path_length(path_length),
        .has_query(has_query),
        .query_length(query_length),
        .header_offset(header_offset)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                line_check.note_request_byte(data_byte, last_byte);
            if (out_valid && !out_stall)
                line_check.check_result(hrlp_result_t'{status, method_code, path_length,
                                                       has_query, query_length,
                                                       header_offset});
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("http_request_line_parser regression: fail");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever the trigger moves.
    initial
    begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(negedge clk);
            if (hold_trigger != hold_seen)
            begin
                hold_seen = hold_trigger;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] c, input bit fin);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= c;
        last_byte <= fin;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic send_request(input logic [7:0] q[$]);
        for (int i = 0; i < q.size(); i++)
            send_byte(q[i], i == q.size() - 1);
    endtask

    function automatic void put_text(ref logic [7:0] q[$], input string s, input bit mixed);
        logic [7:0] ch;
        for (int i = 0; i < s.len(); i++)
        begin
            ch = s[i];
            if (mixed && ch >= "a" && ch <= "z" && $urandom_range(0, 1) == 1)
                ch = ch - 8'd32;
            q.push_back(ch);
        end
    endfunction

    // Mostly well-formed request lines with random content; some are broken,
    // cut short, poisoned with a zero byte, or plain noise.
    function automatic void build_request(ref logic [7:0] q[$]);
        string verb;
        string ver;
        int n;
        int cut;
        int line_len;
        logic [7:0] ch;
        q.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        case ($urandom_range(0, 7))
            0: verb = "get";
            1: verb = "post";
            2: verb = "put";
            3: verb = "delete";
            4: verb = "connect";
            5: verb = "options";
            6: verb = "trace";
            default: verb = "head";
        endcase
        case ($urandom_range(0, 24))
            0: verb = verb.substr(0, verb.len() - 2);
            1: verb = {verb, "s"};
            2: verb[$urandom_range(0, verb.len() - 1)] = 8'($urandom_range(97, 122));
            3: verb = "";
            default: ;
        endcase
        put_text(q, verb, 1'b1);
        q.push_back(CH_SPACE);
        n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 24);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                ch = CH_QUERY;
            else if ($urandom_range(0, 9) == 0)
                ch = 8'($urandom_range(1, 255));
            else
                ch = 8'($urandom_range(33, 126));
            if (ch == CH_SPACE)
                ch = "/";
            q.push_back(ch);
        end
        q.push_back(CH_SPACE);
        case ($urandom_range(0, 19))
            0: ver = "";
            1: ver = "http/1.0";
            2: ver = "http/1.1x";
            3: ver = "http/";
            4: ver = " http/1.1";
            5: ver = "htxp/1.1";
            default: ver = "http/1.1";
        endcase
        put_text(q, ver, 1'b1);
        case ($urandom_range(0, 9))
            0, 1, 2: q.push_back(CH_LF);
            3:
            begin
                q.push_back(CH_CR);
                q.push_back(8'($urandom_range(1, 255)));
            end
            default:
            begin
                q.push_back(CH_CR);
                q.push_back(CH_LF);
            end
        endcase
        line_len = q.size();
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++)
            q.push_back(8'($urandom_range(0, 255)));
        case ($urandom_range(0, 19))
            0, 1, 2:
            begin
                cut = $urandom_range(1, q.size());
                q = q[0:cut-1];
                if (cut < line_len)
                    line_len = cut;
            end
            3: q[$urandom_range(0, line_len - 1)] = CH_NUL;
            default: ;
        endcase
    endfunction

    initial
    begin : stimulus
        logic [7:0] q[$];
        int counted;
        int req_count;
        line_check = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        q = '{CH_NUL};
        send_request(q);
        q = '{8'hFF};
        send_request(q);
        q.delete();
        put_text(q, "Xy /", 1'b0);
        send_request(q);
        q.delete();
        put_text(q, "GET  /", 1'b0);
        send_request(q);
        q.delete();
        put_text(q, "head / ", 1'b0);
        q.push_back(CH_LF);
        send_request(q);
        q.delete();
        put_text(q, "post / h", 1'b0);
        q.push_back(CH_CR);
        q.push_back("x");
        send_request(q);

        counted = 0;
        req_count = 0;
        while (counted < BYTE_TARGET)
        begin
            if (req_count == 15)
            begin
                idle_pct = 0;
                stall_pct = 0;
            end
            if (req_count == 30)
            begin
                // The output is held off while single-byte requests keep coming.
                hold_trigger++;
                for (int i = 0; i < 12; i++)
                begin
                    q = '{(i % 2 == 0) ? CH_NUL : 8'hFF};
                    send_request(q);
                end
                counted += 12;
                idle_pct = 16;
                stall_pct = 16;
            end
            build_request(q);
            send_request(q);
            counted += q.size();
            req_count++;
        end

        in_valid <= 1'b0;
        last_byte <= 1'b0;
        while (line_check.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (line_check.errors == 0)
            $display("http_request_line_parser regression: pass");
        else
            $display("http_request_line_parser regression: fail");
        $finish;
    end

endmodule
